// ----- design/bsc_pkg.sv -----
`default_nettype none
package bsc_pkg;

  // APB register window
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Calibration word and raw conversion widths
  localparam int unsigned CoeffW = 16;
  localparam int unsigned RawW   = 24;

  // Result widths
  localparam int unsigned TempOutW  = 19;
  localparam int unsigned PressOutW = 48;

  // Pipeline depth, input register to output register
  localparam int unsigned NumStages = 8;

  // First-order temperature reference and the two correction thresholds (centi-degrees)
  localparam logic signed [19:0] TempRef  = 20'sd2000;
  localparam logic signed [19:0] TempCold = -20'sd1500;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_SENS     = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_SENS_TC  = 3'd2,
    REG_OFF_TC   = 3'd3,
    REG_REF_TEMP = 3'd4,
    REG_TEMP_TC  = 3'd5
  } reg_idx_e;

endpackage
`default_nettype wire

// ----- design/baro_sensor_compensation.sv -----
`default_nettype none
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+--------------------------------------
// in       | in_valid_i / in_stall_o         | raw_press_i[23:0], raw_temp_i[23:0]
// out      | out_valid_o / out_stall_i       | temp_centi_o[18:0], press_q15_o[47:0]
// cfg      | psel, penable, pwrite, pready   | paddr[4:0], pwdata / prdata[31:0]
//
// Eight register stages; a transaction can enter in every cycle in which in_stall_o is low.
// A result is presented from the output register of the eighth stage.
// Every stage carries its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles collapse; an output stall holds every full stage at once
// and stalls the input only while all eight stages are full.
// Reset clears the valid bits and the six calibration words to zero.
module baro_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] raw_press_i,
  input  logic [23:0] raw_temp_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [18:0] temp_centi_o,
  output logic [47:0] press_q15_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsc_pkg::*;

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [CoeffW-1:0] sens_q, offset_q, sens_tc_q, off_tc_q, ref_temp_q, temp_tc_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q     <= '0;
      offset_q   <= '0;
      sens_tc_q  <= '0;
      off_tc_q   <= '0;
      ref_temp_q <= '0;
      temp_tc_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SENS:     sens_q     <= pwdata[CoeffW-1:0];
        REG_OFFSET:   offset_q   <= pwdata[CoeffW-1:0];
        REG_SENS_TC:  sens_tc_q  <= pwdata[CoeffW-1:0];
        REG_OFF_TC:   off_tc_q   <= pwdata[CoeffW-1:0];
        REG_REF_TEMP: ref_temp_q <= pwdata[CoeffW-1:0];
        REG_TEMP_TC:  temp_tc_q  <= pwdata[CoeffW-1:0];
        default:      ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (reg_idx)
      REG_SENS:     prdata = {{(DataW-CoeffW){1'b0}}, sens_q};
      REG_OFFSET:   prdata = {{(DataW-CoeffW){1'b0}}, offset_q};
      REG_SENS_TC:  prdata = {{(DataW-CoeffW){1'b0}}, sens_tc_q};
      REG_OFF_TC:   prdata = {{(DataW-CoeffW){1'b0}}, off_tc_q};
      REG_REF_TEMP: prdata = {{(DataW-CoeffW){1'b0}}, ref_temp_q};
      REG_TEMP_TC:  prdata = {{(DataW-CoeffW){1'b0}}, temp_tc_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] load;

  always_comb begin
    load[NumStages-1] = ~valid_q[NumStages-1] | ~out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = ~valid_q[k] | load[k+1];
    end
  end

  assign in_stall_o = ~load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: dT = raw_temp - ref_temp * 256
  // ---------------------------------------------------------------------------
  logic signed [24:0]  s1_dt_d, s1_dt_q;
  logic [RawW-1:0]     s1_press_q;

  assign s1_dt_d = $signed({1'b0, raw_temp_i}) - $signed({1'b0, ref_temp_q, 8'd0});

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_dt_q    <= s1_dt_d;
      s1_press_q <= raw_press_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the four products of dT
  // ---------------------------------------------------------------------------
  logic signed [41:0] s2_mt_d, s2_mo_d, s2_ms_d;
  logic signed [49:0] s2_dsq_d;
  logic signed [41:0] s2_mt_q, s2_mo_q, s2_ms_q;
  logic signed [49:0] s2_dsq_q;
  logic [RawW-1:0]    s2_press_q;

  assign s2_mt_d  = s1_dt_q * $signed({1'b0, temp_tc_q});
  assign s2_mo_d  = s1_dt_q * $signed({1'b0, off_tc_q});
  assign s2_ms_d  = s1_dt_q * $signed({1'b0, sens_tc_q});
  assign s2_dsq_d = s1_dt_q * s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s2_mt_q    <= s2_mt_d;
      s2_mo_q    <= s2_mo_d;
      s2_ms_q    <= s2_ms_d;
      s2_dsq_q   <= s2_dsq_d;
      s2_press_q <= s1_press_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: TEMP, OFF, SENS, T2 (divides round toward zero via sign bias)
  // ---------------------------------------------------------------------------
  logic signed [41:0] s3_mt_b, s3_mo_b, s3_ms_b;
  logic signed [19:0] s3_temp_d, s3_temp_q;
  logic signed [35:0] s3_off_d, s3_off_q;
  logic signed [35:0] s3_sens_d, s3_sens_q;
  logic [18:0]        s3_t2_q;
  logic [RawW-1:0]    s3_press_q;

  assign s3_mt_b = s2_mt_q + $signed({19'd0, {23{s2_mt_q[41]}}});
  assign s3_mo_b = s2_mo_q + $signed({35'd0, {7{s2_mo_q[41]}}});
  assign s3_ms_b = s2_ms_q + $signed({34'd0, {8{s2_ms_q[41]}}});

  assign s3_temp_d = TempRef + $signed({s3_mt_b[41], s3_mt_b[41:23]});
  assign s3_off_d  = $signed({4'd0, offset_q, 16'd0}) + $signed({s3_mo_b[41], s3_mo_b[41:7]});
  assign s3_sens_d = $signed({5'd0, sens_q, 15'd0})
                   + $signed({{2{s3_ms_b[41]}}, s3_ms_b[41:8]});

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s3_temp_q  <= s3_temp_d;
      s3_off_q   <= s3_off_d;
      s3_sens_q  <= s3_sens_d;
      s3_t2_q    <= s2_dsq_q[49:31];
      s3_press_q <= s2_press_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squares of (TEMP - 2000) and (TEMP + 1500), range flags
  // ---------------------------------------------------------------------------
  logic signed [20:0] s4_d, s4_e;
  logic signed [41:0] s4_sq_full, s4_sq2_full;
  logic [36:0]        s4_sq_q, s4_sq2_q;
  logic               s4_lt_q, s4_vlt_q;
  logic signed [19:0] s4_temp_q;
  logic [18:0]        s4_t2_q;
  logic signed [35:0] s4_off_q, s4_sens_q;
  logic [RawW-1:0]    s4_press_q;

  assign s4_d        = $signed({s3_temp_q[19], s3_temp_q}) - $signed({TempRef[19], TempRef});
  assign s4_e        = $signed({s3_temp_q[19], s3_temp_q}) - $signed({TempCold[19], TempCold});
  assign s4_sq_full  = s4_d * s4_d;
  assign s4_sq2_full = s4_e * s4_e;

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s4_sq_q    <= s4_sq_full[36:0];
      s4_sq2_q   <= s4_sq2_full[36:0];
      s4_lt_q    <= s3_temp_q < TempRef;
      s4_vlt_q   <= s3_temp_q < TempCold;
      s4_temp_q  <= s3_temp_q;
      s4_t2_q    <= s3_t2_q;
      s4_off_q   <= s3_off_q;
      s4_sens_q  <= s3_sens_q;
      s4_press_q <= s3_press_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: second-order corrections applied
  // ---------------------------------------------------------------------------
  logic [39:0]        s5_sq5, s5_sq2x7;
  logic [40:0]        s5_sq2x11;
  logic [40:0]        s5_off2, s5_sens2;
  logic signed [41:0] s5_off_d, s5_sens_d, s5_off_q, s5_sens_q;
  logic signed [19:0] s5_tout_d, s5_tout_q;
  logic [RawW-1:0]    s5_press_q;

  assign s5_sq5    = {1'b0, s4_sq_q, 2'd0} + {3'd0, s4_sq_q};
  assign s5_sq2x7  = {s4_sq2_q, 3'd0} - {3'd0, s4_sq2_q};
  assign s5_sq2x11 = {1'b0, s4_sq2_q, 3'd0} + {3'd0, s4_sq2_q, 1'b0} + {4'd0, s4_sq2_q};

  always_comb begin
    s5_off2  = '0;
    s5_sens2 = '0;
    if (s4_lt_q) begin
      s5_off2  = {2'd0, s5_sq5[39:1]};
      s5_sens2 = {3'd0, s5_sq5[39:2]};
      if (s4_vlt_q) begin
        s5_off2  = s5_off2 + {1'b0, s5_sq2x7};
        s5_sens2 = s5_sens2 + {1'b0, s5_sq2x11[40:1]};
      end
    end
  end

  assign s5_off_d  = $signed({{6{s4_off_q[35]}}, s4_off_q}) - $signed({1'b0, s5_off2});
  assign s5_sens_d = $signed({{6{s4_sens_q[35]}}, s4_sens_q}) - $signed({1'b0, s5_sens2});
  assign s5_tout_d = s4_lt_q ? s4_temp_q - $signed({1'b0, s4_t2_q}) : s4_temp_q;

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      s5_off_q   <= s5_off_d;
      s5_sens_q  <= s5_sens_d;
      s5_tout_q  <= s5_tout_d;
      s5_press_q <= s4_press_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: press * SENS as two partial products (low 24 bits, signed top)
  // ---------------------------------------------------------------------------
  logic [47:0]        s6_plo_d, s6_plo_q;
  logic signed [42:0] s6_phi_d, s6_phi_q;
  logic signed [41:0] s6_off_q;
  logic signed [19:0] s6_tout_q;

  assign s6_plo_d = s5_press_q * s5_sens_q[23:0];
  assign s6_phi_d = $signed({1'b0, s5_press_q}) * $signed(s5_sens_q[41:24]);

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      s6_plo_q  <= s6_plo_d;
      s6_phi_q  <= s6_phi_d;
      s6_off_q  <= s5_off_q;
      s6_tout_q <= s5_tout_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: combine partial products
  // ---------------------------------------------------------------------------
  logic signed [66:0] s7_prod_d, s7_prod_q;
  logic signed [41:0] s7_off_q;
  logic signed [19:0] s7_tout_q;

  assign s7_prod_d = $signed({s6_phi_q, 24'd0}) + $signed({19'd0, s6_plo_q});

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      s7_prod_q <= s7_prod_d;
      s7_off_q  <= s6_off_q;
      s7_tout_q <= s6_tout_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: divide by 2^21 toward zero, subtract OFF, output register
  // ---------------------------------------------------------------------------
  logic signed [66:0] s8_prod_b;
  logic signed [47:0] s8_press_d;
  logic [TempOutW-1:0]  s8_temp_q;
  logic [PressOutW-1:0] s8_press_q;

  assign s8_prod_b  = s7_prod_q + $signed({46'd0, {21{s7_prod_q[66]}}});
  assign s8_press_d = $signed({{2{s8_prod_b[66]}}, s8_prod_b[66:21]})
                    - $signed({{6{s7_off_q[41]}}, s7_off_q});

  always_ff @(posedge clk_i) begin
    if (load[7]) begin
      s8_temp_q  <= s7_tout_q[TempOutW-1:0];
      s8_press_q <= s8_press_d;
    end
  end

  assign out_valid_o  = valid_q[NumStages-1];
  assign temp_centi_o = s8_temp_q;
  assign press_q15_o  = s8_press_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // input is only held off when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> &valid_q)
    else $error("input stalled with a free pipeline stage");

  // an empty pipeline always takes a transaction
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q == '0) |-> !in_stall_o)
    else $error("empty pipeline stalled input");

  // a stalled result is kept
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NumStages-1] && out_stall_i) |=> valid_q[NumStages-1])
    else $error("stalled result dropped");

  // a result taken with one right behind is followed by it at once
  a_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && valid_q[NumStages-2]) |=> out_valid_o)
    else $error("bubble inserted behind a taken result");

endmodule
`default_nettype wire
